[sv/aas_pkg.sv]
// Shared types, codes and helpers for the aligned access splitter.
package aas_pkg;

  localparam int MAX_READ_BYTES_DEFAULT = 128;
  localparam int RUN_COUNT_W = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_DATA  = 2'd2;

  localparam logic [2:0] KIND_READ  = 3'd0;
  localparam logic [2:0] KIND_WRITE = 3'd1;
  localparam logic [2:0] KIND_EMPTY = 3'd2;
  localparam logic [2:0] KIND_RANGE = 3'd3;
  localparam logic [2:0] KIND_LONG  = 3'd4;
  localparam logic [2:0] KIND_STRAY = 3'd5;

  typedef struct packed {
    logic                   run;
    logic [2:0]             kind;
    logic [31:0]            address;
    logic [2:0]             bytes;
    logic [31:0]            value;
    logic [RUN_COUNT_W-1:0] count;
  } cmd_t;

  function automatic logic [2:0] size_for(input logic [1:0] addr_low,
                                          input logic lt2, input logic lt4);
    logic [2:0] sz;
    if (addr_low[0] || lt2) begin
      sz = 3'd1;
    end else if (addr_low[1] || lt4) begin
      sz = 3'd2;
    end else begin
      sz = 3'd4;
    end
    return sz;
  endfunction

endpackage

[sv/aas_req_if.sv]
// Request channel: opcode, range and write data byte.
interface aas_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] start_address;
  logic [31:0] byte_count;
  logic [7:0]  data_byte;

  modport source(output valid, opcode, start_address, byte_count, data_byte,
                 input ready);
  modport sink(input valid, opcode, start_address, byte_count, data_byte,
               output ready);
endinterface

[sv/aas_res_if.sv]
// Result channel: one access or status per item.
interface aas_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] access_address;
  logic [2:0]  access_bytes;
  logic [31:0] write_value;
  logic        last;

  modport source(output valid, kind, access_address, access_bytes, write_value, last,
                 input ready);
  modport sink(input valid, kind, access_address, access_bytes, write_value, last,
               output ready);
endinterface

[sv/aas_front.sv]
// Front end: accepts items, checks ranges, gathers write bytes, queues commands.
module aas_front #(
  parameter int MAX_READ_BYTES = aas_pkg::MAX_READ_BYTES_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  aas_req_if.sink       req,
  input  logic          q_full,
  output logic          push,
  output aas_pkg::cmd_t push_cmd
);
  import aas_pkg::*;

  logic        writing, writing_next;
  logic [31:0] next_address, next_address_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [31:0] gathered_value, gathered_value_next;
  logic [2:0]  gathered_count, gathered_count_next;
  logic [2:0]  access_size, access_size_next;

  logic        accept;
  logic [32:0] range_end;
  logic        range_err;
  logic [31:0] merged;
  logic [2:0]  count_inc;
  logic [31:0] left_sub;
  logic [31:0] addr_inc;

  assign req.ready = !q_full;
  assign accept    = req.valid && !q_full;
  assign range_end = {1'b0, req.start_address} + {1'b0, req.byte_count};
  assign range_err = range_end[32] && (range_end[31:0] != 32'd0);
  assign count_inc = gathered_count + 3'd1;
  assign left_sub  = (bytes_left >= {29'd0, access_size}) ?
                     bytes_left - {29'd0, access_size} : 32'd0;
  assign addr_inc  = next_address + {29'd0, access_size};

  always_comb begin
    case (gathered_count[1:0])
      2'd0:    merged = gathered_value | {24'd0, req.data_byte};
      2'd1:    merged = gathered_value | {16'd0, req.data_byte, 8'd0};
      2'd2:    merged = gathered_value | {8'd0, req.data_byte, 16'd0};
      default: merged = gathered_value | {req.data_byte, 24'd0};
    endcase
  end

  always_comb begin
    writing_next        = writing;
    next_address_next   = next_address;
    bytes_left_next     = bytes_left;
    gathered_value_next = gathered_value;
    gathered_count_next = gathered_count;
    access_size_next    = access_size;
    push                = 1'b0;
    push_cmd            = '0;
    if (accept) begin
      unique case (req.opcode) inside
        OP_READ, OP_WRITE: begin
          writing_next        = 1'b0;
          gathered_value_next = '0;
          gathered_count_next = '0;
          push                = 1'b1;
          if (range_err) begin
            push_cmd.kind = KIND_RANGE;
          end else if (req.opcode == OP_READ &&
                       req.byte_count > 32'(MAX_READ_BYTES)) begin
            push_cmd.kind = KIND_LONG;
          end else if (req.byte_count == 32'd0) begin
            push_cmd.kind = KIND_EMPTY;
          end else if (req.opcode == OP_READ) begin
            push_cmd.run     = 1'b1;
            push_cmd.kind    = KIND_READ;
            push_cmd.address = req.start_address;
            push_cmd.count   = req.byte_count[RUN_COUNT_W-1:0];
          end else begin
            // arm the write; data bytes follow
            push              = 1'b0;
            writing_next      = 1'b1;
            next_address_next = req.start_address;
            bytes_left_next   = req.byte_count;
            access_size_next  = size_for(req.start_address[1:0],
                                         req.byte_count < 32'd2,
                                         req.byte_count < 32'd4);
          end
        end
        OP_DATA: begin
          if (!writing) begin
            push          = 1'b1;
            push_cmd.kind = KIND_STRAY;
          end else if (count_inc == access_size) begin
            push                = 1'b1;
            push_cmd.kind       = KIND_WRITE;
            push_cmd.address    = next_address;
            push_cmd.bytes      = access_size;
            push_cmd.value      = merged;
            next_address_next   = addr_inc;
            bytes_left_next     = left_sub;
            gathered_value_next = '0;
            gathered_count_next = '0;
            if (left_sub == 32'd0) begin
              writing_next     = 1'b0;
              access_size_next = '0;
            end else begin
              access_size_next = size_for(addr_inc[1:0], left_sub < 32'd2,
                                          left_sub < 32'd4);
            end
          end else begin
            gathered_value_next = merged;
            gathered_count_next = count_inc;
          end
        end
        default: begin
          // unused opcode: drop
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      writing        <= 1'b0;
      next_address   <= '0;
      bytes_left     <= '0;
      gathered_value <= '0;
      gathered_count <= '0;
      access_size    <= '0;
    end else begin
      writing        <= writing_next;
      next_address   <= next_address_next;
      bytes_left     <= bytes_left_next;
      gathered_value <= gathered_value_next;
      gathered_count <= gathered_count_next;
      access_size    <= access_size_next;
    end
  end

endmodule

[sv/aas_queue.sv]
// Short command queue between the front and back ends.
module aas_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  aas_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output aas_pkg::cmd_t pop_cmd,
  output logic          empty
);
  import aas_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;

  assign full    = fill == (PTR_W + 1)'(QUEUE_DEPTH);
  assign empty   = fill == '0;
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end
  end

endmodule

[sv/aas_back.sv]
// Back end: expands read runs one access a cycle while its result register is free, and drives that register.
module aas_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  aas_pkg::cmd_t q_cmd,
  output logic          pop,
  aas_res_if.source     res
);
  import aas_pkg::*;

  logic                   run_active, run_active_next;
  logic [31:0]            run_addr, run_addr_next;
  logic [RUN_COUNT_W-1:0] run_left, run_left_next;

  logic        out_valid, out_valid_next;
  logic [2:0]  out_kind, out_kind_next;
  logic [31:0] out_addr, out_addr_next;
  logic [2:0]  out_bytes, out_bytes_next;
  logic [31:0] out_value, out_value_next;
  logic        out_last, out_last_next;

  logic                   out_free;
  logic [31:0]            src_addr;
  logic [RUN_COUNT_W-1:0] src_left;
  logic [2:0]             sz;
  logic [RUN_COUNT_W-1:0] left_after;

  assign out_free   = !out_valid || res.ready;
  assign src_addr   = run_active ? run_addr : q_cmd.address;
  assign src_left   = run_active ? run_left : q_cmd.count;
  assign sz         = size_for(src_addr[1:0], src_left < RUN_COUNT_W'(2),
                               src_left < RUN_COUNT_W'(4));
  assign left_after = src_left - RUN_COUNT_W'(sz);

  always_comb begin
    pop             = 1'b0;
    run_active_next = run_active;
    run_addr_next   = run_addr;
    run_left_next   = run_left;
    out_valid_next  = out_valid && !res.ready;
    out_kind_next   = out_kind;
    out_addr_next   = out_addr;
    out_bytes_next  = out_bytes;
    out_value_next  = out_value;
    out_last_next   = out_last;
    if (out_free && (run_active || !q_empty)) begin
      out_valid_next = 1'b1;
      pop            = !run_active;
      if (run_active || q_cmd.run) begin
        // emit the next read access, advance the run
        out_kind_next   = KIND_READ;
        out_addr_next   = src_addr;
        out_bytes_next  = sz;
        out_value_next  = '0;
        out_last_next   = left_after == '0;
        run_active_next = left_after != '0;
        run_addr_next   = src_addr + {29'd0, sz};
        run_left_next   = left_after;
      end else begin
        out_kind_next  = q_cmd.kind;
        out_addr_next  = q_cmd.address;
        out_bytes_next = q_cmd.bytes;
        out_value_next = q_cmd.value;
        out_last_next  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_active <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      run_active <= run_active_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    run_addr  <= run_addr_next;
    run_left  <= run_left_next;
    out_kind  <= out_kind_next;
    out_addr  <= out_addr_next;
    out_bytes <= out_bytes_next;
    out_value <= out_value_next;
    out_last  <= out_last_next;
  end

  assign res.valid          = out_valid;
  assign res.kind           = out_kind;
  assign res.access_address = out_addr;
  assign res.access_bytes   = out_bytes;
  assign res.write_value    = out_value;
  assign res.last           = out_last;

endmodule

[sv/aligned_access_splitter.sv]
// Path: an accepted item's result is registered in the command queue, then in the output register.
// Throughput: one item per cycle while the four-entry command queue has room;
// results leave at one per cycle from the back end's output register while the
// receiver is ready, and a read of N accesses gives N results.
// Reset (synchronous, rst high) empties the queue, drops any run or armed write.
module aligned_access_splitter #(
  parameter int MAX_READ_BYTES = aas_pkg::MAX_READ_BYTES_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  aas_req_if.sink   req,
  aas_res_if.source res
);
  import aas_pkg::*;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  aas_front #(
    .MAX_READ_BYTES(MAX_READ_BYTES)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .req(req),
    .q_full(q_full),
    .push(push),
    .push_cmd(push_cmd)
  );

  aas_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_cmd(push_cmd),
    .full(q_full),
    .pop(pop),
    .pop_cmd(pop_cmd),
    .empty(q_empty)
  );

  aas_back u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .q_cmd(pop_cmd),
    .pop(pop),
    .res(res)
  );

endmodule

[sv/aas_checker.sv]
// Port-level checks on the splitter's result stream, bound to the top level.
module aas_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  res_kind,
  input logic [31:0] res_access_address,
  input logic [2:0]  res_access_bytes,
  input logic [31:0] res_write_value,
  input logic        res_last
);
  import aas_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_kind) &&
      $stable(res_access_address) && $stable(res_access_bytes) &&
      $stable(res_write_value) && $stable(res_last))
    else $error("stalled result changed");

  a_aligned: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_kind == KIND_READ || res_kind == KIND_WRITE) |->
      (res_access_bytes == 3'd1) ||
      (res_access_bytes == 3'd2 && !res_access_address[0]) ||
      (res_access_bytes == 3'd4 && res_access_address[1:0] == 2'd0))
    else $error("access misaligned or bad size");

  a_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind != KIND_READ && res_kind != KIND_WRITE |->
      res_last && res_access_bytes == 3'd0 && res_access_address == 32'd0 &&
      res_write_value == 32'd0)
    else $error("status result carries access fields");

  a_read_value: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == KIND_READ |-> res_write_value == 32'd0)
    else $error("read access carries write data");

endmodule

bind aligned_access_splitter aas_checker u_aas_checker (
  .clk(clk),
  .rst(rst),
  .res_valid(res.valid),
  .res_ready(res.ready),
  .res_kind(res.kind),
  .res_access_address(res.access_address),
  .res_access_bytes(res.access_bytes),
  .res_write_value(res.write_value),
  .res_last(res.last)
);
